### sv/assert_macros.svh
// Assertion macros for the RTL top level; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

### sv/nvnt_pkg.sv
// Shared types and constants for the nearest vertex search block.
`timescale 1ns / 1ps

package nvnt_pkg;

    // Default sizes of the vertex store and of the item fields
    localparam int DEF_MAX_SOURCE_VERTICES = 4096;
    localparam int DEF_POSITION_BITS       = 24;
    localparam int DEF_NORMAL_BITS         = 16;

    // Fixed field widths
    localparam int MODE_W   = 2;
    localparam int TOL_W    = 20;
    localparam int INDEX_W  = 12;
    localparam int STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_QUERY = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    clear;       // empty the store
        logic    load;        // store the incoming vertex unless full
        logic    start;       // capture query target, rewind scan address
        logic    issue;       // read one entry and advance the address
        logic    finish;      // write the query result
        logic    res_imm;     // write a result without a scan
        status_t res_status;  // status for the result written without a scan
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic issue_last;
        logic pipe_idle;
    } sts_t;

endpackage

### sv/nvnt_ctrl.sv
// Controller state machine: handshakes, mode decode and scan sequencing.
`timescale 1ns / 1ps

module nvnt_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [nvnt_pkg::MODE_W-1:0] s_mode,
    output logic                       m_valid,
    input  logic                       m_ready,
    input  nvnt_pkg::sts_t             sts,
    output nvnt_pkg::cmd_t             cmd
);
    import nvnt_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    // State and result valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_status = STATUS_OK;
        s_ready        = 1'b0;
        accept         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // take an item only when the result slot is free or freeing
                s_ready = !m_valid_reg || m_ready;
                accept  = s_valid && s_ready;
                if (accept) begin
                    case (mode_t'(s_mode))
                        MODE_CLEAR: begin
                            cmd.clear   = 1'b1;
                            cmd.res_imm = 1'b1;
                        end
                        MODE_LOAD: begin
                            cmd.load       = 1'b1;
                            cmd.res_imm    = 1'b1;
                            cmd.res_status = sts.full ? STATUS_FULL : STATUS_OK;
                        end
                        MODE_QUERY: begin
                            if (sts.empty) begin
                                cmd.res_imm    = 1'b1;
                                cmd.res_status = STATUS_EMPTY;
                            end else begin
                                cmd.start  = 1'b1;
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            cmd.res_imm = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // read one stored entry per cycle
                cmd.issue = 1'b1;
                if (sts.issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the last entry to leave the compare stage
                if (sts.pipe_idle) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_valid_next = (m_valid_reg && !m_ready) || cmd.res_imm || cmd.finish;
    end

    assign m_valid = m_valid_reg;

endmodule

### sv/nvnt_datapath.sv
// Datapath: vertex store, distance and dot pipeline, best tracker, result register.
`timescale 1ns / 1ps

module nvnt_datapath #(
    parameter int MAX_SOURCE_VERTICES = nvnt_pkg::DEF_MAX_SOURCE_VERTICES,
    parameter int POSITION_BITS       = nvnt_pkg::DEF_POSITION_BITS,
    parameter int NORMAL_BITS         = nvnt_pkg::DEF_NORMAL_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  nvnt_pkg::cmd_t                    cmd,
    output nvnt_pkg::sts_t                    sts,
    input  logic                              cfg_we,
    input  logic [nvnt_pkg::TOL_W-1:0]        cfg_wdata,
    input  logic signed [POSITION_BITS-1:0]   s_pos_x,
    input  logic signed [POSITION_BITS-1:0]   s_pos_y,
    input  logic signed [POSITION_BITS-1:0]   s_pos_z,
    input  logic signed [NORMAL_BITS-1:0]     s_norm_x,
    input  logic signed [NORMAL_BITS-1:0]     s_norm_y,
    input  logic signed [NORMAL_BITS-1:0]     s_norm_z,
    output logic [nvnt_pkg::INDEX_W-1:0]      m_best_index,
    output logic                              m_found,
    output logic [nvnt_pkg::STATUS_W-1:0]     m_status
);
    import nvnt_pkg::*;

    localparam int PB     = POSITION_BITS;
    localparam int NB     = NORMAL_BITS;
    localparam int AW     = $clog2(MAX_SOURCE_VERTICES);
    localparam int CW     = $clog2(MAX_SOURCE_VERTICES + 1);
    localparam int ENT_W  = 3 * PB + 3 * NB;
    localparam int DIFF_W = PB + 1;
    localparam int SQ_W   = 2 * PB + 1;
    localparam int SUM_W  = SQ_W + 2;
    localparam int PROD_W = 2 * NB;
    localparam int DOT_W  = PROD_W + 2;
    localparam int CMP_W  = ((SUM_W > TOL_W) ? SUM_W : TOL_W) + 1;

    // Store and fill count
    logic [ENT_W-1:0] mem [MAX_SOURCE_VERTICES];
    logic [CW-1:0]    count_reg;
    logic [TOL_W-1:0] tol_reg;
    logic             full;

    // Query target and scan address
    logic signed [PB-1:0] tgt_x_reg, tgt_y_reg, tgt_z_reg;
    logic signed [NB-1:0] tgt_nx_reg, tgt_ny_reg, tgt_nz_reg;
    logic [AW-1:0]        addr_reg;

    // Pipeline registers
    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic [AW-1:0]            idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [ENT_W-1:0]         rd_data_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [NB-1:0]     nx2_reg, ny2_reg, nz2_reg;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg, sqz_reg;
    logic signed [PROD_W-1:0] px_reg, py_reg, pz_reg;
    logic [SUM_W-1:0]         d_reg;
    logic signed [DOT_W-1:0]  dot_reg;

    // Best so far
    logic [AW-1:0]            best_idx_reg;
    logic [SUM_W-1:0]         best_d_reg;
    logic signed [DOT_W-1:0]  best_dot_reg;

    // Result register
    logic [INDEX_W-1:0] res_idx_reg;
    logic               res_found_reg;
    status_t            res_status_reg;

    logic signed [PB-1:0]       rd_x, rd_y, rd_z;
    logic signed [NB-1:0]       rd_nx, rd_ny, rd_nz;
    logic signed [2*DIFF_W-1:0] sq_full_x, sq_full_y, sq_full_z;
    logic signed [CMP_W-1:0]    gap, tol_s;
    logic                       closer, in_tol, dot_gt, take;

    assign full = (count_reg == CW'(MAX_SOURCE_VERTICES));

    assign sts.empty      = (count_reg == '0);
    assign sts.full       = full;
    assign sts.issue_last = (addr_reg == AW'(count_reg - 1'b1));
    assign sts.pipe_idle  = !(v1_reg || v2_reg || v3_reg || v4_reg);

    // Tolerance register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
        end else if (cfg_we) begin
            tol_reg <= cfg_wdata;
        end
    end

    // Fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.clear) begin
            count_reg <= '0;
        end else if (cmd.load && !full) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    // Write a loaded vertex at the fill position
    always_ff @(posedge aclk) begin
        if (cmd.load && !full) begin
            mem[count_reg[AW-1:0]] <= {s_pos_x, s_pos_y, s_pos_z,
                                       s_norm_x, s_norm_y, s_norm_z};
        end
    end

    // Registered read of the scanned entry
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    // Capture target, advance scan address
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            tgt_x_reg  <= s_pos_x;
            tgt_y_reg  <= s_pos_y;
            tgt_z_reg  <= s_pos_z;
            tgt_nx_reg <= s_norm_x;
            tgt_ny_reg <= s_norm_y;
            tgt_nz_reg <= s_norm_z;
            addr_reg   <= '0;
        end else if (cmd.issue) begin
            addr_reg   <= addr_reg + 1'b1;
        end
    end

    // Stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Unpack the read entry
    assign rd_x  = rd_data_reg[ENT_W-1 -: PB];
    assign rd_y  = rd_data_reg[ENT_W-1-PB -: PB];
    assign rd_z  = rd_data_reg[ENT_W-1-2*PB -: PB];
    assign rd_nx = rd_data_reg[3*NB-1 -: NB];
    assign rd_ny = rd_data_reg[2*NB-1 -: NB];
    assign rd_nz = rd_data_reg[NB-1 -: NB];

    assign sq_full_x = dx_reg * dx_reg;
    assign sq_full_y = dy_reg * dy_reg;
    assign sq_full_z = dz_reg * dz_reg;

    // Differences, products, sums
    always_ff @(posedge aclk) begin
        idx1_reg <= addr_reg;

        dx_reg   <= DIFF_W'(rd_x) - DIFF_W'(tgt_x_reg);
        dy_reg   <= DIFF_W'(rd_y) - DIFF_W'(tgt_y_reg);
        dz_reg   <= DIFF_W'(rd_z) - DIFF_W'(tgt_z_reg);
        nx2_reg  <= rd_nx;
        ny2_reg  <= rd_ny;
        nz2_reg  <= rd_nz;
        idx2_reg <= idx1_reg;

        sqx_reg  <= sq_full_x[SQ_W-1:0];
        sqy_reg  <= sq_full_y[SQ_W-1:0];
        sqz_reg  <= sq_full_z[SQ_W-1:0];
        px_reg   <= nx2_reg * tgt_nx_reg;
        py_reg   <= ny2_reg * tgt_ny_reg;
        pz_reg   <= nz2_reg * tgt_nz_reg;
        idx3_reg <= idx2_reg;

        d_reg    <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
        dot_reg  <= DOT_W'(px_reg) + DOT_W'(py_reg) + DOT_W'(pz_reg);
        idx4_reg <= idx3_reg;
    end

    // Compare candidate against best so far
    always_comb begin
        gap    = $signed(CMP_W'(d_reg)) - $signed(CMP_W'(best_d_reg));
        tol_s  = $signed(CMP_W'(tol_reg));
        closer = gap[CMP_W-1];
        in_tol = (gap <= tol_s) && (gap >= -tol_s);
        dot_gt = (dot_reg > best_dot_reg);
        take   = (idx4_reg == '0) || closer || (in_tol && dot_gt);
    end

    // Update best
    always_ff @(posedge aclk) begin
        if (v4_reg && take) begin
            best_idx_reg <= idx4_reg;
            best_d_reg   <= d_reg;
            best_dot_reg <= dot_reg;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.res_imm) begin
            res_idx_reg    <= '0;
            res_found_reg  <= 1'b0;
            res_status_reg <= cmd.res_status;
        end else if (cmd.finish) begin
            res_idx_reg    <= INDEX_W'(best_idx_reg);
            res_found_reg  <= 1'b1;
            res_status_reg <= STATUS_OK;
        end
    end

    assign m_best_index = res_idx_reg;
    assign m_found      = res_found_reg;
    assign m_status     = res_status_reg;

endmodule

### sv/nearest_vertex_normal_tiebreak.sv
// Top level of the nearest source vertex search with normal tie-break.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+---------------------
//   input    | s_mode, s_pos_x/y/z, s_norm_x/y/z        | s_valid / s_ready
//   result   | m_best_index, m_found, m_status          | m_valid / m_ready
//   config   | cfg_wdata (distance tolerance)           | cfg_we, no wait
//
// Clear, load and unused-mode items write their result without a scan.
// A query reads one stored entry per cycle through the single read port of
// the vertex store into a pipeline of read, difference, product and sum stages.
// One item is in work at a time; a new item is taken once the result register
// is empty or being emptied. Reset is synchronous, active low, and empties
// the store at once through the fill count; no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nearest_vertex_normal_tiebreak #(
    parameter int MAX_SOURCE_VERTICES = nvnt_pkg::DEF_MAX_SOURCE_VERTICES,
    parameter int POSITION_BITS       = nvnt_pkg::DEF_POSITION_BITS,
    parameter int NORMAL_BITS         = nvnt_pkg::DEF_NORMAL_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [nvnt_pkg::TOL_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [nvnt_pkg::MODE_W-1:0]       s_mode,
    input  logic signed [POSITION_BITS-1:0]   s_pos_x,
    input  logic signed [POSITION_BITS-1:0]   s_pos_y,
    input  logic signed [POSITION_BITS-1:0]   s_pos_z,
    input  logic signed [NORMAL_BITS-1:0]     s_norm_x,
    input  logic signed [NORMAL_BITS-1:0]     s_norm_y,
    input  logic signed [NORMAL_BITS-1:0]     s_norm_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [nvnt_pkg::INDEX_W-1:0]      m_best_index,
    output logic                              m_found,
    output logic [nvnt_pkg::STATUS_W-1:0]     m_status
);
    import nvnt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencing and handshakes
    nvnt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Store, arithmetic and result register
    nvnt_datapath #(
        .MAX_SOURCE_VERTICES (MAX_SOURCE_VERTICES),
        .POSITION_BITS       (POSITION_BITS),
        .NORMAL_BITS         (NORMAL_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_pos_z      (s_pos_z),
        .s_norm_x     (s_norm_x),
        .s_norm_y     (s_norm_y),
        .s_norm_z     (s_norm_z),
        .m_best_index (m_best_index),
        .m_found      (m_found),
        .m_status     (m_status)
    );

    // No new item may enter while entries are being scanned
    `ASSERT_IMPLIES(a_no_accept_in_scan, aclk, aresetn, cmd.issue, !s_ready, "item taken during scan")
    // Scanning an empty store would read unwritten entries
    `ASSERT_IMPLIES(a_issue_not_empty, aclk, aresetn, cmd.issue, !sts.empty, "scan of empty store")
    // Query result only after the last entry left the pipeline
    `ASSERT_IMPLIES(a_finish_idle, aclk, aresetn, cmd.finish, sts.pipe_idle, "result before pipeline drained")
    // A new result never overwrites one still waiting
    `ASSERT_IMPLIES(a_no_overwrite, aclk, aresetn, cmd.res_imm || cmd.finish, !m_valid || m_ready, "result overwritten")

endmodule
